// ----- hdl/sfsc_pkg.sv -----
// Shared types, constants and helpers for the SYN flood source counter.
`default_nettype none

package sfsc_pkg;

  localparam int unsigned IP_W     = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned EIDX_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_INTERVAL = 2'd1;

  localparam logic [CFG_W-1:0] ALARM_LEVEL_RST    = 16'd10;
  localparam logic [CFG_W-1:0] CLEAR_INTERVAL_RST = 16'd1;

  // Item kinds as sorted by the front end.
  typedef enum logic [1:0] {
    CMD_OTHER = 2'd0,  // packet that is not SYN-only
    CMD_SYN   = 2'd1,  // SYN without ACK, gets counted
    CMD_TICK  = 2'd2   // one time tick
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [IP_W-1:0] ip;
  } cmd_t;

  typedef struct packed {
    logic              flood_alarm;
    logic              table_full;
    logic [CNT_W-1:0]  hit_count;
    logic [EIDX_W-1:0] entry_index;
    logic              counts_cleared;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_CLEAR  = 4'b1000
  } state_e;

  // Increment that sticks at the top value.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sfsc_front.sv -----
// Front end: takes transactions and sorts them into queue commands.
`default_nettype none

module sfsc_front import sfsc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            func_i,
  input  wire logic [IP_W-1:0] source_ip_i,
  input  wire logic            syn_flag_i,
  input  wire logic            ack_flag_i,
  input  wire logic            q_full_i,
  output logic                 busy_o,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  // Registered busy so the port never follows start combinationally.
  logic busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = q_full_i | busy_q;
  assign push_o = start_i & ~busy_o;

  always_comb begin
    cmd_o.ip = source_ip_i;
    if (func_i) begin
      cmd_o.kind = CMD_TICK;
    end else if (syn_flag_i && !ack_flag_i) begin
      cmd_o.kind = CMD_SYN;
    end else begin
      cmd_o.kind = CMD_OTHER;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfsc_queue.sv -----
// Two-entry command queue between the front end and the table engine.
`default_nettype none

module sfsc_queue import sfsc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_data_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign empty_o = (fill_q == 2'd0);
  assign full_o  = (fill_q == 2'd2);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfsc_back.sv -----
// Table engine: source lookup, count update and interval clear.
`default_nettype none

module sfsc_back import sfsc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  cmd_t                      q_head_i,
  input  wire logic                 q_empty_i,
  output logic                      pop_o,
  output logic                      done_o,
  output result_t                   res_o
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [USED_W-1:0] DEPTH_U = USED_W'(TABLE_DEPTH);

  // Tables
  logic [IP_W-1:0]  addr_mem [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_mem  [TABLE_DEPTH];
  logic [IP_W-1:0]  addr_rd_q;
  logic [CNT_W-1:0] cnt_rd_q;

  logic             addr_re, addr_we;
  logic [IDX_W-1:0] addr_ra, addr_wa;
  logic             cnt_re, cnt_we;
  logic [IDX_W-1:0] cnt_ra, cnt_wa;
  logic [CNT_W-1:0] cnt_wd;

  // Control state
  state_e            state_q, state_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [CNT_W-1:0]  ticks_q, ticks_d;
  logic [CFG_W-1:0]  thr_q, intv_q;
  logic [IP_W-1:0]   ip_q, ip_d;
  logic [USED_W-1:0] scan_q, scan_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              new_q, new_d;
  logic [USED_W-1:0] wi_q, wi_d;
  logic              done_q, done_d;
  result_t           res_q, res_d;

  logic              hit;
  logic [CNT_W-1:0]  tick_inc, cnt_base, cnt_inc;
  logic              alarm;
  logic [USED_W-1:0] wi_inc;

  assign hit      = cmp_vld_q && (addr_rd_q == ip_q);
  assign tick_inc = sat_inc(ticks_q);
  assign cnt_base = new_q ? '0 : cnt_rd_q;
  assign cnt_inc  = sat_inc(cnt_base);
  assign alarm    = (cnt_inc >= thr_q);
  assign wi_inc   = wi_q + USED_W'(1);

  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    ticks_d   = ticks_q;
    ip_d      = ip_q;
    scan_d    = scan_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    slot_d    = slot_q;
    new_d     = new_q;
    wi_d      = wi_q;
    done_d    = 1'b0;
    res_d     = '0;
    pop_o     = 1'b0;
    addr_re   = 1'b0;
    addr_ra   = scan_q[IDX_W-1:0];
    addr_we   = 1'b0;
    addr_wa   = used_q[IDX_W-1:0];
    cnt_re    = 1'b0;
    cnt_ra    = cmp_idx_q;
    cnt_we    = 1'b0;
    cnt_wa    = slot_q;
    cnt_wd    = '0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          case (q_head_i.kind)
            CMD_TICK: begin
              done_d = 1'b1;
              if (tick_inc >= intv_q) begin
                ticks_d              = '0;
                res_d.counts_cleared = 1'b1;
                if (used_q != '0) begin
                  wi_d    = '0;
                  state_d = ST_CLEAR;
                end
              end else begin
                ticks_d = tick_inc;
              end
            end
            CMD_SYN: begin
              ip_d    = q_head_i.ip;
              scan_d  = '0;
              state_d = ST_SCAN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          cnt_re  = 1'b1;
          slot_d  = cmp_idx_q;
          new_d   = 1'b0;
          state_d = ST_UPDATE;
        end else if (scan_q < used_q) begin
          addr_re   = 1'b1;
          cmp_idx_d = scan_q[IDX_W-1:0];
          cmp_vld_d = 1'b1;
          scan_d    = scan_q + USED_W'(1);
        end else if (used_q >= DEPTH_U) begin
          res_d.table_full = 1'b1;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          addr_we = 1'b1;
          slot_d  = used_q[IDX_W-1:0];
          new_d   = 1'b1;
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        cnt_we            = 1'b1;
        cnt_wd            = alarm ? '0 : cnt_inc;
        res_d.hit_count   = cnt_inc;
        res_d.entry_index = EIDX_W'(slot_q);
        res_d.flood_alarm = alarm;
        done_d            = 1'b1;
        if (new_q) begin
          used_d = used_q + USED_W'(1);
        end
        state_d = ST_IDLE;
      end

      ST_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = wi_q[IDX_W-1:0];
        wi_d   = wi_inc;
        if (wi_inc >= used_q) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      ticks_q   <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
      thr_q     <= ALARM_LEVEL_RST;
      intv_q    <= CLEAR_INTERVAL_RST;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      ticks_q   <= ticks_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALARM_LEVEL:    thr_q  <= cfg_wdata_i;
          REG_CLEAR_INTERVAL: intv_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    ip_q      <= ip_d;
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    new_q     <= new_d;
    wi_q      <= wi_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[addr_wa] <= ip_q;
    end
    if (addr_re) begin
      addr_rd_q <= addr_mem[addr_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_ra];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/syn_flood_source_counter.sv -----
// Top level of the per-source SYN rate counter.
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start_i high
//   and busy_o low. func_i = 0 is a packet (source_ip_i, syn_flag_i,
//   ack_flag_i), func_i = 1 is one time tick.
//   Result channel: every transaction yields one result, shown for exactly
//   one cycle with done_o high. The receiver cannot stall; results leave in
//   input order.
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 alarm threshold, 1 clear interval); other indexes are dropped.
//   Write only while idle.
// Timing:
//   Front end queues up to two transactions, so busy_o rises only when the
//   queue is full. The engine reads one stored address per cycle from the
//   address memory, so the time a SYN packet takes grows with entries_used
//   (TABLE_DEPTH at most); a tick or non-SYN packet yields its result
//   without a search. A tick that ends the interval then walks the count
//   memory, one entry per cycle, before the next transaction.
// Reset: the table is emptied (used count to zero), tick counter cleared,
//   registers back to threshold 10 and interval 1. No clearing pass.
`default_nettype none

module syn_flood_source_counter import sfsc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 func_i,
  input  wire logic [IP_W-1:0]      source_ip_i,
  input  wire logic                 syn_flag_i,
  input  wire logic                 ack_flag_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                      done_o,
  output logic                      flood_alarm_o,
  output logic                      table_full_o,
  output logic [CNT_W-1:0]          hit_count_o,
  output logic [EIDX_W-1:0]         entry_index_o,
  output logic                      counts_cleared_o
);

  // front -> queue
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  // queue -> back
  cmd_t    q_head;
  logic    q_empty;
  logic    pop;
  result_t res;

  sfsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .func_i      (func_i),
    .source_ip_i (source_ip_i),
    .syn_flag_i  (syn_flag_i),
    .ack_flag_i  (ack_flag_i),
    .q_full_i    (q_full),
    .busy_o      (busy_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  sfsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  sfsc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_head_i    (q_head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .done_o      (done_o),
    .res_o       (res)
  );

  assign flood_alarm_o    = res.flood_alarm;
  assign table_full_o     = res.table_full;
  assign hit_count_o      = res.hit_count;
  assign entry_index_o    = res.entry_index;
  assign counts_cleared_o = res.counts_cleared;

endmodule

`default_nettype wire
